@@ rtl/assert_macros.svh @@
// assertion macros used by the top rtl file of the lcd mode timing controller
// needs clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle implication failed");

`endif

@@ rtl/lmtc_pkg.sv @@
// types and constants of the lcd mode timing controller
// no dependencies
`default_nettype none

package lmtc_pkg;

    typedef enum logic [1:0] {
        CMD_ADVANCE = 2'd0,
        CMD_LCDC    = 2'd1,
        CMD_LYC     = 2'd2,
        CMD_STAT    = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] elapsed_ticks;
        logic [7:0] write_value;
        logic       cpu_halted;
        logic       hdma_active;
    } lmtc_in_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] line;
        logic [6:0] status_byte;
        logic       vblank_irq;
        logic       stat_irq;
        logic       render_pulse;
        logic       hdma_pulse;
        logic       last;
    } lmtc_out_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       halted;
        logic       hdma;
    } lmtc_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_OFF,
        BK_RUN
    } back_state_t;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    localparam logic [7:0] LCDC_RESET = 8'h91;
    localparam int         LCDC_ON    = 7;

    localparam logic [6:0] STAT_MODE_CLEAR = 7'h7C;
    localparam logic [6:0] STAT_COINC_IRQ  = 7'h44;
    localparam logic [6:0] STAT_LOW_KEEP   = 7'h07;
    localparam logic [6:0] STAT_ENABLES    = 7'h78;

    localparam logic [7:0] LINE_VBLANK = 8'd144;
    localparam logic [7:0] LINE_SHORT  = 8'd152;
    localparam logic [7:0] LINE_MAX    = 8'd153;

    localparam logic signed [10:0] DUR_SEARCH     = 11'sd40;
    localparam logic signed [10:0] DUR_XFER       = 11'sd86;
    localparam logic signed [10:0] DUR_HBLANK     = 11'sd102;
    localparam logic signed [10:0] DUR_LINE       = 11'sd228;
    localparam logic signed [10:0] DUR_VBL_RAISE  = 11'sd218;
    localparam logic signed [10:0] DUR_VBL_QUICK  = 11'sd10;
    localparam logic signed [10:0] DUR_SHORT_LINE = 11'sd28;
    localparam logic signed [10:0] DUR_WRAP       = 11'sd200;

    localparam logic signed [9:0]  BAL_RESET = 10'sd40;
    localparam logic signed [11:0] BAL_MIN   = -12'sd512;
    localparam logic signed [11:0] BAL_MAX   = 12'sd511;

    localparam int STEP_LIMIT       = 32;
    localparam int LMTC_QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

@@ rtl/lmtc_front.sv @@
// front end: takes requests, decodes the function code into a command
// depends on lmtc_pkg
`default_nettype none

module lmtc_front
    import lmtc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire lmtc_in_t  cmd_data,
    output logic           push_valid,
    output lmtc_cmd_t      push_cmd,
    input  wire logic      q_full
);

    logic      valid_reg;
    logic      valid_next;
    lmtc_cmd_t cmd_reg;
    lmtc_cmd_t cmd_next;
    logic      accept;

    assign cmd_stall  = valid_reg && q_full;
    assign accept     = cmd_valid && !cmd_stall;
    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;

    always_comb
    begin
        cmd_next.kind   = cmd_kind_t'(cmd_data.func);
        cmd_next.halted = cmd_data.cpu_halted;
        cmd_next.hdma   = cmd_data.hdma_active;
        unique case (cmd_next.kind)
            CMD_ADVANCE: cmd_next.data = cmd_data.elapsed_ticks;
            CMD_LCDC, CMD_LYC, CMD_STAT: cmd_next.data = cmd_data.write_value;
            default: cmd_next.data = cmd_data.write_value;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (!q_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lmtc_queue.sv @@
// short command queue between front end and back end
// depends on lmtc_pkg
`default_nettype none

module lmtc_queue
    import lmtc_pkg::*;
#(
    parameter int DEPTH = LMTC_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    input  wire lmtc_cmd_t push_cmd,
    output logic           full,
    input  wire logic      pop,
    output logic           pop_valid,
    output lmtc_cmd_t      pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lmtc_cmd_t       mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = mem[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lmtc_back.sv @@
// back end: display timing state, mode steps and result register
// depends on lmtc_pkg
`default_nettype none

module lmtc_back
    import lmtc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_valid,
    input  wire lmtc_cmd_t q_cmd,
    output logic           q_pop,
    output logic           res_valid,
    input  wire logic      res_stall,
    output lmtc_out_t      res_data
);

    localparam int SW = $clog2(STEP_LIMIT);

    typedef struct packed {
        logic [7:0]        lcdc;
        logic [6:0]        stat;
        logic [7:0]        ly;
        logic [7:0]        lyc;
        logic signed [9:0] bal;
        logic              vbl;
    } ppu_t;

    typedef struct packed {
        ppu_t p;
        logic rp;
        logic hp;
    } step_t;

    function automatic logic signed [9:0] sat_add(logic signed [9:0] b,
                                                  logic signed [10:0] d);
        logic signed [11:0] s;
        s = {{2{b[9]}}, b} + {d[10], d};
        if (s < BAL_MIN)
        begin
            return BAL_MIN[9:0];
        end
        if (s > BAL_MAX)
        begin
            return BAL_MAX[9:0];
        end
        return s[9:0];
    endfunction

    function automatic ppu_t refresh(ppu_t p);
        p.stat[2] = (p.ly == p.lyc);
        return p;
    endfunction

    function automatic ppu_t enter_mode(ppu_t p, logic [1:0] m);
        p.stat = (p.stat & STAT_MODE_CLEAR) | {5'b0, m};
        if (m != MODE_VBLANK)
        begin
            p.vbl = 1'b0;
        end
        return refresh(p);
    endfunction

    function automatic logic stat_level(ppu_t p);
        logic sel;
        unique case (p.stat[1:0])
            MODE_HBLANK: sel = p.stat[3];
            MODE_VBLANK: sel = p.stat[4];
            MODE_SEARCH: sel = p.stat[5];
            MODE_XFER:   sel = 1'b0;
            default:     sel = 1'b0;
        endcase
        return p.lcdc[LCDC_ON] && (((p.stat & STAT_COINC_IRQ) == STAT_COINC_IRQ) || sel);
    endfunction

    function automatic lmtc_out_t make_result(ppu_t p, logic rp, logic hp, logic lst);
        lmtc_out_t r;
        r.mode         = p.stat[1:0];
        r.line         = p.ly;
        r.status_byte  = p.stat;
        r.vblank_irq   = p.vbl;
        r.stat_irq     = stat_level(p);
        r.render_pulse = rp;
        r.hdma_pulse   = hp;
        r.last         = lst;
        return r;
    endfunction

    function automatic step_t on_step(ppu_t p, logic halted, logic hdma);
        step_t s;
        s.rp = 1'b0;
        s.hp = 1'b0;
        unique case (p.stat[1:0])
            MODE_HBLANK:
            begin
                p.ly = p.ly + 8'd1;
                if (p.ly >= LINE_VBLANK)
                begin
                    if (halted)
                    begin
                        p.vbl = 1'b1;
                        p.bal = sat_add(p.bal, DUR_LINE);
                    end
                    else
                    begin
                        p.bal = sat_add(p.bal, DUR_VBL_QUICK);
                    end
                    p = enter_mode(p, MODE_VBLANK);
                end
                else
                begin
                    p = enter_mode(p, MODE_SEARCH);
                    p.bal = sat_add(p.bal, DUR_SEARCH);
                end
            end
            MODE_VBLANK:
            begin
                if (!p.vbl)
                begin
                    p.vbl = 1'b1;
                    p.bal = sat_add(p.bal, DUR_VBL_RAISE);
                end
                else if (p.ly == 8'd0)
                begin
                    p = enter_mode(p, MODE_SEARCH);
                    p.bal = sat_add(p.bal, DUR_SEARCH);
                end
                else
                begin
                    if (p.ly < LINE_SHORT)
                    begin
                        p.bal = sat_add(p.bal, DUR_LINE);
                        p.ly  = p.ly + 8'd1;
                    end
                    else if (p.ly == LINE_SHORT)
                    begin
                        p.bal = sat_add(p.bal, DUR_SHORT_LINE);
                        p.ly  = p.ly + 8'd1;
                    end
                    else
                    begin
                        p.bal = sat_add(p.bal, DUR_WRAP);
                        p.ly  = 8'd0;
                    end
                    p = refresh(p);
                end
            end
            MODE_SEARCH:
            begin
                s.rp = 1'b1;
                p = enter_mode(p, MODE_XFER);
                p.bal = sat_add(p.bal, DUR_XFER);
            end
            default:
            begin
                p = enter_mode(p, MODE_HBLANK);
                s.hp = hdma;
                p.bal = sat_add(p.bal, DUR_HBLANK);
            end
        endcase
        s.p = p;
        return s;
    endfunction

    function automatic step_t off_step(ppu_t p, logic hdma);
        step_t s;
        s.rp = 1'b0;
        s.hp = 1'b0;
        unique case (p.stat[1:0])
            MODE_HBLANK, MODE_VBLANK:
            begin
                p = enter_mode(p, MODE_SEARCH);
                p.bal = sat_add(p.bal, DUR_SEARCH);
            end
            MODE_SEARCH:
            begin
                p = enter_mode(p, MODE_XFER);
                p.bal = sat_add(p.bal, DUR_XFER);
            end
            default:
            begin
                p = enter_mode(p, MODE_HBLANK);
                s.hp = hdma;
                if (!hdma)
                begin
                    p.bal = sat_add(p.bal, DUR_HBLANK);
                end
            end
        endcase
        s.p = p;
        return s;
    endfunction

    back_state_t   state_reg;
    back_state_t   state_next;
    ppu_t          ppu_reg;
    ppu_t          ppu_next;
    lmtc_cmd_t     cmd_reg;
    lmtc_cmd_t     cmd_next;
    logic [SW-1:0] cnt_reg;
    logic [SW-1:0] cnt_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    lmtc_out_t     out_reg;
    lmtc_out_t     out_next;
    logic          out_free;
    logic          emit;
    logic          lst;
    step_t         st;
    ppu_t          pw;

    assign out_free  = !out_valid_reg || !res_stall;
    assign q_pop     = (state_reg == BK_IDLE) && q_valid;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        ppu_next   = ppu_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg;
        emit       = 1'b0;
        lst        = 1'b0;
        st         = '0;
        pw         = ppu_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next   = q_cmd;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (cmd_reg.kind == CMD_ADVANCE)
                begin
                    pw.bal   = sat_add(ppu_reg.bal, 11'sd0 - $signed({3'b000, cmd_reg.data}));
                    ppu_next = pw;
                    cnt_next = '0;
                    if (pw.bal > 10'sd0)
                    begin
                        state_next = BK_IDLE;
                    end
                    else if (!pw.lcdc[LCDC_ON])
                    begin
                        state_next = BK_OFF;
                    end
                    else
                    begin
                        state_next = BK_RUN;
                    end
                end
                else if (out_free)
                begin
                    unique case (cmd_reg.kind)
                        CMD_LCDC:
                        begin
                            pw.lcdc = cmd_reg.data;
                            if (ppu_reg.lcdc[LCDC_ON] != cmd_reg.data[LCDC_ON])
                            begin
                                pw.ly  = 8'd0;
                                pw     = enter_mode(pw, MODE_SEARCH);
                                pw.bal = BAL_RESET;
                            end
                        end
                        CMD_LYC:
                        begin
                            pw.lyc = cmd_reg.data;
                            pw     = refresh(pw);
                        end
                        default:
                        begin
                            pw.stat = (pw.stat & STAT_LOW_KEEP) | (cmd_reg.data[6:0] & STAT_ENABLES);
                            pw      = refresh(pw);
                        end
                    endcase
                    ppu_next   = pw;
                    out_next   = make_result(pw, 1'b0, 1'b0, 1'b1);
                    emit       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            BK_OFF:
            begin
                if (out_free)
                begin
                    st         = off_step(ppu_reg, cmd_reg.hdma);
                    ppu_next   = st.p;
                    out_next   = make_result(st.p, st.rp, st.hp, 1'b1);
                    emit       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                if (out_free)
                begin
                    st       = on_step(ppu_reg, cmd_reg.halted, cmd_reg.hdma);
                    lst      = (st.p.bal > 10'sd0) || (cnt_reg == SW'(STEP_LIMIT - 1));
                    ppu_next = st.p;
                    out_next = make_result(st.p, st.rp, st.hp, lst);
                    emit     = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (lst)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            ppu_reg.lcdc  <= LCDC_RESET;
            ppu_reg.stat  <= '0;
            ppu_reg.ly    <= '0;
            ppu_reg.lyc   <= '0;
            ppu_reg.bal   <= BAL_RESET;
            ppu_reg.vbl   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            ppu_reg       <= ppu_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

@@ rtl/lcd_mode_timing_controller_top.sv @@
// LCD mode and STAT interrupt timing controller. A request either advances time
// (elapsed_ticks drains the cycle balance) or writes LCDC, LYC or the STAT enable
// bits. A write gives exactly one result; an advance gives zero results while the
// balance stays positive, one result while the display is off, and otherwise one
// result per timing step, at most 32, the final one marked by last. Requests
// pass a decode register and a short queue, so the front side keeps accepting
// while the back end works, until the queue fills. The back end is a sequencer
// that handles one request at a time: idle takes a request, exec applies a write
// or drains the balance by an advance, then the off state gives one display-off
// step, or run gives one step per cycle while the result side does not stall.
// No clearing pass after reset.
// depends on lmtc_pkg, lmtc_front, lmtc_queue, lmtc_back, assert_macros.svh
`default_nettype none

module lcd_mode_timing_controller_top
    import lmtc_pkg::*;
#(
    parameter int QUEUE_DEPTH = LMTC_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire lmtc_in_t  cmd_data,
    output logic           res_valid,
    input  wire logic      res_stall,
    output lmtc_out_t      res_data
);

    logic      push_valid;
    lmtc_cmd_t push_cmd;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    lmtc_cmd_t q_cmd;

    lmtc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_data   (cmd_data),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    lmtc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd)
    );

    lmtc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_line_range, res_valid, res_data.line <= LINE_MAX)
    `ASSERT_IMPLY(a_render_in_xfer, res_valid && res_data.render_pulse, res_data.mode == MODE_XFER)
    `ASSERT_IMPLY(a_hdma_in_hblank, res_valid && res_data.hdma_pulse, res_data.mode == MODE_HBLANK)
    `ASSERT_IMPLY(a_vblank_irq_mode, res_valid && res_data.vblank_irq, res_data.mode == MODE_VBLANK)
    `ASSERT_NEXT(a_chain_continues, res_valid && !res_stall && !res_data.last, res_valid)

endmodule

`default_nettype wire

@@ bench/lcd_mode_timing_controller_top_tb.sv @@
// testbench for lcd_mode_timing_controller_top: a directed table, then random requests
// under several idle and stall mixes, each result checked against an in-bench predictor
// depends on lmtc_pkg and the rtl of the timing controller
`timescale 1ns / 1ps

module lcd_mode_timing_controller_top_tb;
    import lmtc_pkg::*;

    typedef struct {
        lmtc_in_t  req;
        bit        typed;
        lmtc_out_t res;
    } table_row_t;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    lmtc_in_t  cmd_data;
    logic      res_valid;
    logic      res_stall;
    lmtc_out_t res_data;

    // predicted controller state
    logic [7:0] pr_lcdc;
    logic [7:0] pr_ly;
    logic [7:0] pr_lyc;
    logic [6:0] pr_stat;
    logic       pr_vbl;
    int         pr_balance;

    lmtc_out_t  expected_results[$];
    table_row_t directed_rows[$];
    int         mismatch_count;
    int         send_idle_pct;
    int         recv_stall_pct;

    lcd_mode_timing_controller_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic lmtc_in_t make_req(cmd_kind_t k, int ticks, int val, bit halted,
                                          bit hdma);
        lmtc_in_t rq;
        rq.func          = k;
        rq.elapsed_ticks = ticks[7:0];
        rq.write_value   = val[7:0];
        rq.cpu_halted    = halted;
        rq.hdma_active   = hdma;
        return rq;
    endfunction

    function automatic lmtc_out_t make_res(logic [1:0] m, int ln, int st, bit vbl, bit irq);
        lmtc_out_t r;
        r.mode         = m;
        r.line         = ln[7:0];
        r.status_byte  = st[6:0];
        r.vblank_irq   = vbl;
        r.stat_irq     = irq;
        r.render_pulse = 1'b0;
        r.hdma_pulse   = 1'b0;
        r.last         = 1'b1;
        return r;
    endfunction

    task automatic add_row(input lmtc_in_t rq, input bit typed, input lmtc_out_t res);
        table_row_t row;
        row.req   = rq;
        row.typed = typed;
        row.res   = res;
        directed_rows.push_back(row);
    endtask

    function automatic int sat_balance(int b);
        if (b < int'(BAL_MIN))
            return int'(BAL_MIN);
        if (b > int'(BAL_MAX))
            return int'(BAL_MAX);
        return b;
    endfunction

    task automatic add_cycles(input int d);
        pr_balance = sat_balance(pr_balance + d);
    endtask

    task automatic refresh_coinc();
        if (pr_ly == pr_lyc)
            pr_stat = pr_stat | 7'h04;
        else
            pr_stat = pr_stat & 7'h7B;
    endtask

    task automatic enter_mode(input logic [1:0] m);
        pr_stat = (pr_stat & STAT_MODE_CLEAR) | {5'b0, m};
        if (m != MODE_VBLANK)
            pr_vbl = 1'b0;
        refresh_coinc();
    endtask

    function automatic logic stat_line();
        if (!pr_lcdc[LCDC_ON])
            return 1'b0;
        if ((pr_stat & STAT_COINC_IRQ) == STAT_COINC_IRQ)
            return 1'b1;
        case (pr_stat[1:0])
            MODE_HBLANK: return pr_stat[3];
            MODE_VBLANK: return pr_stat[4];
            MODE_SEARCH: return pr_stat[5];
            default:     return 1'b0;
        endcase
    endfunction

    function automatic lmtc_out_t snapshot(bit rp, bit hp, bit lst);
        lmtc_out_t s;
        s.mode         = pr_stat[1:0];
        s.line         = pr_ly;
        s.status_byte  = pr_stat;
        s.vblank_irq   = pr_vbl;
        s.stat_irq     = stat_line();
        s.render_pulse = rp;
        s.hdma_pulse   = hp;
        s.last         = lst;
        return s;
    endfunction

    task automatic lcd_apply_request(input lmtc_in_t rq);
        lmtc_out_t held;
        bit        have_held;
        bit        rp;
        bit        hp;
        int        steps;
        int        ticks;
        have_held = 1'b0;
        steps     = 0;
        hp        = 1'b0;
        ticks     = int'(rq.elapsed_ticks);
        case (rq.func)
            CMD_LCDC:
            begin
                if (pr_lcdc[LCDC_ON] != rq.write_value[LCDC_ON])
                begin
                    pr_ly = 8'd0;
                    enter_mode(MODE_SEARCH);
                    pr_balance = int'(BAL_RESET);
                end
                pr_lcdc = rq.write_value;
            end
            CMD_LYC:
            begin
                pr_lyc = rq.write_value;
                refresh_coinc();
            end
            CMD_STAT:
            begin
                pr_stat = (pr_stat & STAT_LOW_KEEP) | (rq.write_value[6:0] & STAT_ENABLES);
                refresh_coinc();
            end
            default:
            begin
            end
        endcase
        if (rq.func != CMD_ADVANCE)
        begin
            expected_results.push_back(snapshot(1'b0, 1'b0, 1'b1));
            return;
        end
        pr_balance = sat_balance(pr_balance - ticks);
        if (pr_balance > 0)
            return;
        // display off: a single step per request
        if (!pr_lcdc[LCDC_ON])
        begin
            case (pr_stat[1:0])
                MODE_HBLANK, MODE_VBLANK:
                begin
                    enter_mode(MODE_SEARCH);
                    add_cycles(DUR_SEARCH);
                end
                MODE_SEARCH:
                begin
                    enter_mode(MODE_XFER);
                    add_cycles(DUR_XFER);
                end
                default:
                begin
                    enter_mode(MODE_HBLANK);
                    if (rq.hdma_active)
                        hp = 1'b1;
                    else
                        add_cycles(DUR_HBLANK);
                end
            endcase
            expected_results.push_back(snapshot(1'b0, hp, 1'b1));
            return;
        end
        while (pr_balance <= 0 && steps < STEP_LIMIT)
        begin
            rp = 1'b0;
            hp = 1'b0;
            case (pr_stat[1:0])
                MODE_HBLANK:
                begin
                    pr_ly = pr_ly + 8'd1;
                    if (pr_ly >= LINE_VBLANK)
                    begin
                        if (rq.cpu_halted)
                        begin
                            pr_vbl = 1'b1;
                            add_cycles(DUR_LINE);
                        end
                        else
                            add_cycles(DUR_VBL_QUICK);
                        enter_mode(MODE_VBLANK);
                    end
                    else
                    begin
                        enter_mode(MODE_SEARCH);
                        add_cycles(DUR_SEARCH);
                    end
                end
                MODE_VBLANK:
                begin
                    if (!pr_vbl)
                    begin
                        pr_vbl = 1'b1;
                        add_cycles(DUR_VBL_RAISE);
                    end
                    else if (pr_ly == 8'd0)
                    begin
                        enter_mode(MODE_SEARCH);
                        add_cycles(DUR_SEARCH);
                    end
                    else
                    begin
                        if (pr_ly < LINE_SHORT)
                        begin
                            add_cycles(DUR_LINE);
                            pr_ly = pr_ly + 8'd1;
                        end
                        else if (pr_ly == LINE_SHORT)
                        begin
                            add_cycles(DUR_SHORT_LINE);
                            pr_ly = pr_ly + 8'd1;
                        end
                        else
                        begin
                            add_cycles(DUR_WRAP);
                            pr_ly = 8'd0;
                        end
                        refresh_coinc();
                    end
                end
                MODE_SEARCH:
                begin
                    rp = 1'b1;
                    enter_mode(MODE_XFER);
                    add_cycles(DUR_XFER);
                end
                default:
                begin
                    enter_mode(MODE_HBLANK);
                    if (rq.hdma_active)
                        hp = 1'b1;
                    add_cycles(DUR_HBLANK);
                end
            endcase
            if (have_held)
                expected_results.push_back(held);
            held      = snapshot(rp, hp, 1'b0);
            have_held = 1'b1;
            steps++;
        end
        if (have_held)
        begin
            held.last = 1'b1;
            expected_results.push_back(held);
        end
    endtask

    task automatic send_request(input lmtc_in_t rq, input bit typed, input lmtc_out_t res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= rq;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        lcd_apply_request(rq);
        if (typed)
        begin
            void'(expected_results.pop_back());
            expected_results.push_back(res);
        end
    endtask

    function automatic lmtc_in_t random_req();
        lmtc_in_t rq;
        int       pick;
        int       spread;
        rq     = lmtc_in_t'($urandom);
        pick   = $urandom_range(0, 99);
        spread = $urandom_range(0, 9);
        if (pick < 86)
        begin
            rq.func = CMD_ADVANCE;
            if (spread < 7)
                rq.elapsed_ticks = 8'($urandom_range(150, 255));
            else if (spread < 9)
                rq.elapsed_ticks = 8'($urandom_range(0, 149));
            else
                rq.elapsed_ticks = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        else if (pick < 92)
        begin
            rq.func = CMD_LYC;
            if (spread < 8)
                rq.write_value = 8'($urandom_range(0, 153));
        end
        else if (pick < 96)
            rq.func = CMD_STAT;
        else
        begin
            rq.func = CMD_LCDC;
            // mostly leave the display as it is, turn it back on quickly
            if (pr_lcdc[LCDC_ON])
                rq.write_value[LCDC_ON] = ($urandom_range(0, 99) >= 15);
            else
                rq.write_value[LCDC_ON] = ($urandom_range(0, 99) < 70);
        end
        return rq;
    endfunction

    task automatic check_result(input lmtc_out_t got);
        lmtc_out_t want;
        bit        bad;
        if (expected_results.size() == 0)
        begin
            if (mismatch_count < 10)
                $display("unexpected result: mode=%0d line=%0d stat=%h last=%b",
                         got.mode, got.line, got.status_byte, got.last);
            mismatch_count++;
            return;
        end
        want = expected_results.pop_front();
        bad  = (got.mode !== want.mode) || (got.line !== want.line)
            || (got.status_byte !== want.status_byte) || (got.vblank_irq !== want.vblank_irq)
            || (got.stat_irq !== want.stat_irq) || (got.render_pulse !== want.render_pulse)
            || (got.hdma_pulse !== want.hdma_pulse) || (got.last !== want.last);
        if (bad)
        begin
            if (mismatch_count < 10)
            begin
                $display({"mismatch expected: mode=%0d line=%0d stat=%h vbl=%b irq=%b",
                          " rp=%b hp=%b last=%b"},
                         want.mode, want.line, want.status_byte, want.vblank_irq,
                         want.stat_irq, want.render_pulse, want.hdma_pulse, want.last);
                $display({"         actual:   mode=%0d line=%0d stat=%h vbl=%b irq=%b",
                          " rp=%b hp=%b last=%b"},
                         got.mode, got.line, got.status_byte, got.vblank_irq,
                         got.stat_irq, got.render_pulse, got.hdma_pulse, got.last);
            end
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                check_result(res_data);
            res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        lmtc_out_t none;
        int        ph;
        none           = '0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pr_lcdc        = LCDC_RESET;
        pr_stat        = 7'd0;
        pr_ly          = 8'd0;
        pr_lyc         = 8'd0;
        pr_balance     = int'(BAL_RESET);
        pr_vbl         = 1'b0;
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd_data       = '0;
        res_stall      = 1'b0;

        // right after reset the results follow directly from the written bytes
        add_row(make_req(CMD_LYC, 0, 8'h00, 0, 0), 1, make_res(MODE_HBLANK, 0, 7'h04, 0, 0));
        add_row(make_req(CMD_STAT, 0, 8'hFF, 0, 0), 1, make_res(MODE_HBLANK, 0, 7'h7C, 0, 1));
        add_row(make_req(CMD_LYC, 0, 8'hFF, 1, 1), 1, make_res(MODE_HBLANK, 0, 7'h78, 0, 1));
        add_row(make_req(CMD_STAT, 0, 8'h00, 0, 0), 1, make_res(MODE_HBLANK, 0, 7'h00, 0, 0));
        add_row(make_req(CMD_ADVANCE, 0, 8'hFF, 0, 0), 0, none);
        add_row(make_req(CMD_ADVANCE, 39, 8'h00, 0, 0), 0, none);
        add_row(make_req(CMD_ADVANCE, 1, 8'h00, 0, 0), 0, none);
        add_row(make_req(CMD_ADVANCE, 255, 8'h00, 0, 1), 0, none);
        add_row(make_req(CMD_ADVANCE, 255, 8'hFF, 1, 0), 0, none);
        add_row(make_req(CMD_STAT, 0, 8'h78, 0, 0), 0, none);
        add_row(make_req(CMD_LYC, 0, 8'h02, 0, 0), 0, none);
        add_row(make_req(CMD_ADVANCE, 255, 8'h00, 0, 1), 0, none);
        // display off, then drive the balance into saturation
        add_row(make_req(CMD_LCDC, 0, 8'h11, 0, 0), 0, none);
        add_row(make_req(CMD_ADVANCE, 255, 8'h00, 0, 0), 0, none);
        add_row(make_req(CMD_ADVANCE, 255, 8'h00, 0, 1), 0, none);
        add_row(make_req(CMD_ADVANCE, 255, 8'h00, 0, 0), 0, none);
        add_row(make_req(CMD_ADVANCE, 255, 8'h00, 1, 1), 0, none);
        add_row(make_req(CMD_ADVANCE, 255, 8'h00, 0, 0), 0, none);
        add_row(make_req(CMD_LCDC, 0, 8'h91, 0, 0), 0, none);
        add_row(make_req(CMD_LCDC, 0, 8'h93, 0, 0), 0, none);
        add_row(make_req(CMD_ADVANCE, 255, 8'h00, 1, 0), 0, none);
        add_row(make_req(CMD_STAT, 0, 8'hFF, 0, 0), 0, none);
        add_row(make_req(CMD_LYC, 0, 8'h00, 0, 0), 0, none);
        add_row(make_req(CMD_ADVANCE, 255, 8'h00, 1, 1), 0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            // hold off new requests until the controller has drained
            if (ph == 2)
            begin
                cmd_valid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
            repeat (52)
                send_request(random_req(), 1'b0, none);
        end
        cmd_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
